// File: hw/rtl/slru_pkg.sv
// Package with shared types, constants and helpers of the LRU cache tag model.
`default_nettype none

package slru_pkg;

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned SIZE_W = 7;
  localparam int unsigned CNT_W  = 32;

  // Default geometry: 64-byte lines, 8192 lines in total, 16 ways.
  localparam int unsigned LINE_BYTES_DEF  = 64;
  localparam int unsigned TOTAL_LINES_DEF = 8192;
  localparam int unsigned WAYS_DEF        = 16;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] access_size;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic             straddled;
    logic [CNT_W-1:0] load_count;
    logic [CNT_W-1:0] store_count;
    logic [CNT_W-1:0] load_miss_count;
    logic [CNT_W-1:0] store_miss_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;     // Write one zero row of the clearing pass.
    logic load;    // Take a new transaction and read the set of its first line.
    logic rd;      // Read the set of the last line.
    logic sel_b;   // Work on the last line instead of the first one.
    logic wr;      // Write back the updated set row.
    logic finish;  // Update the counters and present the result.
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // The clearing pass writes its last row.
    logic two;       // The current transaction touches two lines.
  } ctrl_sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/slru_ctrl.sv
// Controller state machine that sequences clearing, lookups and write-backs.
`default_nettype none

module slru_ctrl
  import slru_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  ctrl_sts_t  sts_i,
  output ctrl_cmd_t  cmd_o,
  output logic       busy_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_A,
    ST_RD_B,
    ST_UPD_B
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_UPD_A;
        end
      end
      ST_UPD_A: begin
        cmd_o.wr = 1'b1;
        if (sts_i.two) begin
          state_d = ST_RD_B;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_RD_B: begin
        cmd_o.rd    = 1'b1;
        cmd_o.sel_b = 1'b1;
        state_d     = ST_UPD_B;
      end
      ST_UPD_B: begin
        cmd_o.wr     = 1'b1;
        cmd_o.sel_b  = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      busy_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

// File: hw/rtl/slru_lru_upd.sv
// Tag compare and most-recently-used reordering of one set row.
`default_nettype none

module slru_lru_upd #(
  parameter int unsigned WAYS  = 16,
  parameter int unsigned TAG_W = 49
) (
  input  logic [WAYS-1:0][TAG_W-1:0] row_i,
  input  logic [TAG_W-1:0]           tag_i,
  output logic [WAYS-1:0][TAG_W-1:0] row_o,
  output logic                       hit_o
);

  logic [WAYS-1:0] match;
  logic [WAYS-1:0] shift;
  logic            seen;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      match[i] = (row_i[i] == tag_i);
    end
  end

  // A way shifts back when no earlier way matched: that covers every way up
  // to the hit position, or all ways on a miss.
  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      shift[i] = ~seen;
      seen     = seen | match[i];
    end
  end

  always_comb begin
    row_o[0] = tag_i;
    for (int i = 1; i < WAYS; i++) begin
      row_o[i] = shift[i] ? row_i[i-1] : row_i[i];
    end
  end

  assign hit_o = |match;

endmodule

`default_nettype wire

// File: hw/rtl/slru_dpath.sv
// Datapath with the tag memory, transaction registers and access counters.
`default_nettype none

module slru_dpath
  import slru_pkg::*;
#(
  parameter int unsigned LINE_BYTES  = LINE_BYTES_DEF,
  parameter int unsigned TOTAL_LINES = TOTAL_LINES_DEF,
  parameter int unsigned WAYS        = WAYS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  req_t      req_i,
  input  ctrl_cmd_t cmd_i,
  output ctrl_sts_t sts_o,
  output rsp_t      result_o,
  output logic      done_o
);

  localparam int unsigned NUM_SETS = TOTAL_LINES / WAYS;
  localparam int unsigned OFF_W    = $clog2(LINE_BYTES);
  localparam int unsigned SET_W    = $clog2(NUM_SETS);
  localparam int unsigned SET_IW   = (SET_W > 0) ? SET_W : 1;
  localparam int unsigned LINE_W   = ADDR_W - OFF_W;
  localparam int unsigned TAG_W    = LINE_W - SET_W;

  typedef logic [WAYS-1:0][TAG_W-1:0] row_t;

  function automatic logic [SET_IW-1:0] set_of(input logic [LINE_W-1:0] l);
    return SET_IW'(l % NUM_SETS);
  endfunction

  function automatic logic [TAG_W-1:0] tag_of(input logic [LINE_W-1:0] l);
    return TAG_W'(l >> SET_W);
  endfunction

  // Tag memory, one row of all ways per set.
  row_t mem_q [NUM_SETS];
  row_t rdata_q;

  logic [LINE_W-1:0] first_line_q, last_line_q;
  logic              mode_q, two_q, hit_q, hit_res_q, done_q;
  logic [SET_IW-1:0] clr_idx_q;
  logic [CNT_W-1:0]  loads_q, stores_q, load_miss_q, store_miss_q;

  logic [SIZE_W-1:0] size_m1;
  logic [ADDR_W-1:0] last_addr;
  logic [LINE_W-1:0] in_first_line, in_last_line, cur_line;
  logic [SET_IW-1:0] raddr, waddr;
  logic              re, we;
  row_t              wdata, upd_row;
  logic              found, hit_fin;

  // A zero size counts as one byte, so the offset to the last byte is zero.
  assign size_m1 = (req_i.access_size == '0) ? '0 : req_i.access_size - SIZE_W'(1);
  assign last_addr     = req_i.address + ADDR_W'(size_m1);
  assign in_first_line = LINE_W'(req_i.address >> OFF_W);
  assign in_last_line  = LINE_W'(last_addr >> OFF_W);

  assign cur_line = cmd_i.sel_b ? last_line_q : first_line_q;

  slru_lru_upd #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W)
  ) u_lru_upd (
    .row_i (rdata_q),
    .tag_i (tag_of(cur_line)),
    .row_o (upd_row),
    .hit_o (found)
  );

  assign re    = cmd_i.load | cmd_i.rd;
  assign raddr = cmd_i.load ? set_of(in_first_line) : set_of(last_line_q);
  assign we    = cmd_i.clr | cmd_i.wr;
  assign waddr = cmd_i.clr ? clr_idx_q : set_of(cur_line);
  assign wdata = cmd_i.clr ? '0 : upd_row;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Transaction payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q       <= req_i.mode;
      first_line_q <= in_first_line;
      last_line_q  <= in_last_line;
      two_q        <= (in_first_line != in_last_line);
    end
    if (cmd_i.wr) begin
      hit_q <= hit_fin;
    end
    if (cmd_i.finish) begin
      hit_res_q <= hit_fin;
    end
  end

  assign hit_fin = cmd_i.sel_b ? (hit_q & found) : found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q    <= '0;
      done_q       <= 1'b0;
      loads_q      <= '0;
      stores_q     <= '0;
      load_miss_q  <= '0;
      store_miss_q <= '0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.clr) begin
        clr_idx_q <= clr_idx_q + SET_IW'(1);
      end
      if (cmd_i.finish) begin
        if (mode_q) begin
          stores_q <= sat_inc(stores_q);
          if (!hit_fin) begin
            store_miss_q <= sat_inc(store_miss_q);
          end
        end else begin
          loads_q <= sat_inc(loads_q);
          if (!hit_fin) begin
            load_miss_q <= sat_inc(load_miss_q);
          end
        end
      end
    end
  end

  assign sts_o.clr_last = (clr_idx_q == SET_IW'(NUM_SETS - 1));
  assign sts_o.two      = two_q;

  assign result_o.hit              = hit_res_q;
  assign result_o.straddled        = two_q;
  assign result_o.load_count       = loads_q;
  assign result_o.store_count      = stores_q;
  assign result_o.load_miss_count  = load_miss_q;
  assign result_o.store_miss_count = store_miss_q;
  assign done_o                    = done_q;

endmodule

`default_nettype wire

// File: hw/rtl/set_assoc_lru_cache_model.sv
// Top level of the tag-only set-associative cache model with true LRU.
//
// Usage: a transaction (mode, byte address, access size) is taken at a rising
// clock edge where start_i is high and busy_o is low. Exactly one result
// follows on result_o, valid for the single cycle in which done_o is high;
// the receiver cannot stall it and must take it in that cycle.
// busy_o is high from acceptance until the result cycle, in which it is
// already low, so the next transaction can be taken at the edge that ends
// that cycle. An access within one line is a read of its whole set row from
// the tag memory followed by a write-back of the reordered row; an access
// that straddles two lines goes through these steps for each line in turn.
// After reset the block runs a clearing pass that writes zero to every set
// row, one row per cycle (TOTAL_LINES / WAYS rows, 512 by default), with
// busy_o held high. All counters reset to zero and saturate at their maximum.
`default_nettype none

module set_assoc_lru_cache_model
  import slru_pkg::*;
#(
  parameter int unsigned LINE_BYTES  = LINE_BYTES_DEF,
  parameter int unsigned TOTAL_LINES = TOTAL_LINES_DEF,
  parameter int unsigned WAYS        = WAYS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output rsp_t result_o,
  output logic done_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // The controller walks each transaction through its lookup and write-back
  // steps; the datapath owns the tag memory and all counters.
  slru_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  slru_dpath #(
    .LINE_BYTES  (LINE_BYTES),
    .TOTAL_LINES (TOTAL_LINES),
    .WAYS        (WAYS)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .result_o (result_o),
    .done_o   (done_o)
  );

endmodule

`default_nettype wire

// File: test/set_assoc_lru_cache_model_test.sv
// Self-checking testbench for the LRU set-associative cache tag model.
`timescale 1ns / 1ps

module set_assoc_lru_cache_model_test;
  import slru_pkg::*;

  // Cache geometry as the block is built by default.
  localparam int unsigned NUM_SETS  = TOTAL_LINES_DEF / WAYS_DEF;
  localparam int unsigned OFFSET_W  = $clog2(LINE_BYTES_DEF);
  localparam int unsigned SET_W     = $clog2(NUM_SETS);
  localparam int unsigned TAG_W     = ADDR_W - OFFSET_W - SET_W;

  // Random traffic volume and run limits. The slowest correct run, with every
  // access straddling two lines, the sender's gaps and the clearing pass, stays
  // well below this limit.
  localparam int unsigned RANDOM_ACCESSES = 1125;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned MAX_REPORTS     = 10;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_STORE = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  req_t req_i;
  rsp_t result_o;
  logic done_o;

  set_assoc_lru_cache_model dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .req_i    (req_i),
    .result_o (result_o),
    .done_o   (done_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state. Every set row is an MRU-first list of tags. All tags are
  // zero after reset, so any line with tag zero hits until it ages out.
  // ---------------------------------------------------------------------------
  bit [TAG_W-1:0]  lru_rows [NUM_SETS][WAYS_DEF];
  bit [CNT_W-1:0]  loads_pred;
  bit [CNT_W-1:0]  stores_pred;
  bit [CNT_W-1:0]  load_misses_pred;
  bit [CNT_W-1:0]  store_misses_pred;

  // Results still owed by the block, oldest first.
  rsp_t            pending_rsp_q [$];

  int unsigned     mismatch_cnt = 0;
  int unsigned     cycle_cnt = 0;

  // Hot working set used by the random traffic: a handful of sets and more
  // tags than there are ways, so rows fill up and evictions happen often.
  logic [SET_W-1:0] hot_sets [8];
  logic [TAG_W-1:0] hot_tags [24];

  function automatic bit [CNT_W-1:0] bump_count(input bit [CNT_W-1:0] cnt);
    return (&cnt) ? cnt : cnt + CNT_W'(1);
  endfunction

  // Reference one line in its set and reorder the row. Returns 1 on a hit.
  // On a miss the least recently used way falls off the end.
  function automatic bit lru_reference(input logic [ADDR_W-1:0] line);
    int unsigned    set_idx;
    bit [TAG_W-1:0] line_tag;
    int             pos;
    bit             found;
    set_idx  = int'(line % NUM_SETS);
    line_tag = TAG_W'(line / NUM_SETS);
    pos      = WAYS_DEF - 1;
    found    = 1'b0;
    for (int w = 0; w < WAYS_DEF; w++) begin
      if (!found && lru_rows[set_idx][w] == line_tag) begin
        pos   = w;
        found = 1'b1;
      end
    end
    for (int w = pos; w > 0; w--) begin
      lru_rows[set_idx][w] = lru_rows[set_idx][w-1];
    end
    lru_rows[set_idx][0] = line_tag;
    return found;
  endfunction

  // Work out the result of one access and advance the predictor state.
  // A zero size counts as one byte and the end address wraps at 2^64. Only
  // the first and the last line are referenced, first one first.
  function automatic rsp_t predict_access(input req_t r);
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] last_byte;
    logic [ADDR_W-1:0] first_line;
    logic [ADDR_W-1:0] last_line;
    bit                hit;
    bit                two;
    rsp_t              p;
    span       = (r.access_size == '0) ? ADDR_W'(1) : ADDR_W'(r.access_size);
    last_byte  = r.address + span - ADDR_W'(1);
    first_line = r.address / LINE_BYTES_DEF;
    last_line  = last_byte / LINE_BYTES_DEF;
    two        = (first_line != last_line);
    hit        = lru_reference(first_line);
    if (two) begin
      hit = lru_reference(last_line) && hit;
    end
    if (r.mode == MODE_STORE) begin
      stores_pred = bump_count(stores_pred);
      if (!hit) store_misses_pred = bump_count(store_misses_pred);
    end else begin
      loads_pred = bump_count(loads_pred);
      if (!hit) load_misses_pred = bump_count(load_misses_pred);
    end
    p.hit              = hit;
    p.straddled        = two;
    p.load_count       = loads_pred;
    p.store_count      = stores_pred;
    p.load_miss_count  = load_misses_pred;
    p.store_miss_count = store_misses_pred;
    return p;
  endfunction

  function automatic logic [ADDR_W-1:0] line_address(input logic [TAG_W-1:0] tag,
                                                     input logic [SET_W-1:0] set_idx,
                                                     input logic [OFFSET_W-1:0] offset);
    return {tag, set_idx, offset};
  endfunction

  function automatic req_t make_access(input logic mode, input logic [ADDR_W-1:0] addr,
                                       input int unsigned size);
    req_t r;
    r.mode        = mode;
    r.address     = addr;
    r.access_size = SIZE_W'(size);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Inputs change only by nonblocking assignments right after a rising
  // edge. start_i stays high from one transaction to the next when there is
  // no gap, so it gets a single assignment per time step.
  // ---------------------------------------------------------------------------
  task automatic issue_access(input req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    // The transaction is taken at the first edge where busy_o was low.
    do @(posedge clk_i); while (busy_o);
    pending_rsp_q.push_back(predict_access(r));
  endtask

  task automatic idle_sender(input int unsigned cycles);
    if (cycles != 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Hold the sender off until every owed result has come back.
  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker. done_o and result_o are read right after the edge, so the
  // values seen are the ones the edge sampled.
  // ---------------------------------------------------------------------------
  task automatic note_failure(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string field_name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      note_failure($sformatf("%s expected 0x%08h, got 0x%08h", field_name, want, got));
    end
  endtask

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_rsp_q.size() == 0) begin
        note_failure("result with no transaction outstanding");
      end else begin
        want = pending_rsp_q.pop_front();
        check_field("hit", CNT_W'(want.hit), CNT_W'(result_o.hit));
        check_field("straddled", CNT_W'(want.straddled), CNT_W'(result_o.straddled));
        check_field("load_count", want.load_count, result_o.load_count);
        check_field("store_count", want.store_count, result_o.store_count);
        check_field("load_miss_count", want.load_miss_count, result_o.load_miss_count);
        check_field("store_miss_count", want.store_miss_count, result_o.store_miss_count);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** set_assoc_lru_cache_model: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh rows hold only tag zero, so the first accesses to low memory hit.
  // The first one also uses a zero size, which must act as a single byte.
  task automatic test_reset_tags();
    issue_access(make_access(MODE_LOAD, '0, 0));
    issue_access(make_access(MODE_STORE, line_address('0, '1, '0), 64));
  endtask

  // Largest size reaching three lines (the middle one must not be touched),
  // a full-line size that straddles, and a one-byte access at a line's end.
  task automatic test_size_extremes();
    issue_access(make_access(MODE_LOAD, line_address(TAG_W'(3), 9'd40, '1), 127));
    issue_access(make_access(MODE_STORE, line_address(TAG_W'(3), 9'd41, 6'd1), 64));
    issue_access(make_access(MODE_LOAD, line_address(TAG_W'(3), 9'd41, '1), 1));
  endtask

  // The end address wraps past the top of the address space into line zero.
  task automatic test_address_wrap();
    issue_access(make_access(MODE_STORE, '1, 2));
    issue_access(make_access(MODE_LOAD, ADDR_W'(-10), 127));
  endtask

  // Fill one row with sixteen new tags, which pushes out tag zero. The oldest
  // survivor must still hit and move to the front; then tag zero misses and
  // evicts what is now the least recently used way.
  task automatic test_lru_order();
    for (int t = 1; t <= WAYS_DEF; t++) begin
      issue_access(make_access(t[0], line_address(TAG_W'(t), 9'd7, 6'(t)), 4));
    end
    issue_access(make_access(MODE_LOAD, line_address(TAG_W'(1), 9'd7, '0), 8));
    issue_access(make_access(MODE_STORE, line_address('0, 9'd7, '0), 8));
  endtask

  function automatic req_t random_access();
    int unsigned       pick;
    int unsigned       size;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    // Sizes lean toward short accesses; the whole encoding still shows up.
    size = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 16);
    if (pick < 60) begin
      // Hot working set: hits, misses and evictions in a few busy rows.
      addr = line_address(hot_tags[$urandom_range(0, 23)], hot_sets[$urandom_range(0, 7)],
                          OFFSET_W'($urandom_range(0, LINE_BYTES_DEF - 1)));
    end else if (pick < 75) begin
      // Near the end of a hot line, so the access tends to spill over.
      addr = line_address(hot_tags[$urandom_range(0, 23)], hot_sets[$urandom_range(0, 7)],
                          OFFSET_W'($urandom_range(LINE_BYTES_DEF - 8, LINE_BYTES_DEF - 1)));
      size = $urandom_range(2, 127);
    end else if (pick < 90) begin
      addr = {$urandom, $urandom};
      size = $urandom_range(0, 127);
    end else if (pick < 95) begin
      // Top of the address space, where the end address wraps around.
      addr = ADDR_W'(-1) - ADDR_W'($urandom_range(0, 200));
      size = $urandom_range(0, 127);
    end else begin
      // Low memory with tag zero.
      addr = ADDR_W'($urandom_range(0, LINE_BYTES_DEF * NUM_SETS - 1));
    end
    return make_access(logic'($urandom_range(0, 1)), addr, size);
  endfunction

  // Random traffic sent in bursts with random gaps. Some bursts run back to
  // back, and once halfway the sender waits until the block has caught up.
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned burst_len;
    bit          drained;
    for (int i = 0; i < 8; i++) hot_sets[i] = SET_W'($urandom_range(0, NUM_SETS - 1));
    hot_sets[7] = '1;
    for (int i = 0; i < 24; i++) begin
      hot_tags[i] = (i < 4) ? TAG_W'(i) : TAG_W'({$urandom, $urandom});
    end
    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_ACCESSES) begin
      burst_len = $urandom_range(1, 24);
      for (int b = 0; b < burst_len && sent < RANDOM_ACCESSES; b++) begin
        issue_access(random_access());
        sent++;
      end
      if (!drained && sent >= RANDOM_ACCESSES / 2) begin
        drain_results();
        drained = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        idle_sender($urandom_range(1, 7));
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    req_i        = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The clearing pass after reset keeps busy_o high; the first transaction
    // simply waits for it.
    test_reset_tags();
    test_size_extremes();
    test_address_wrap();
    test_lru_order();
    test_random_traffic();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_rsp_q.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", pending_rsp_q.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("** set_assoc_lru_cache_model: PASSED **");
    end else begin
      $display("** set_assoc_lru_cache_model: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/slru_pkg.sv
hw/rtl/slru_ctrl.sv
hw/rtl/slru_lru_upd.sv
hw/rtl/slru_dpath.sv
hw/rtl/set_assoc_lru_cache_model.sv
test/set_assoc_lru_cache_model_test.sv
